### sv/clns_pkg.sv
// shared types, constants and init sequence table for the lcd nibble sequencer
`default_nettype none
package clns_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned STEP_W     = 5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ENABLE_HIGH = 2'd0;
    localparam logic [1:0] REG_SETTLE      = 2'd1;
    localparam logic [1:0] REG_LONG_CMD    = 2'd2;
    localparam logic [1:0] REG_POWER_ON    = 2'd3;

    localparam logic [7:0]  RST_ENABLE_HIGH = 8'd1;
    localparam logic [15:0] RST_SETTLE      = 16'd100;
    localparam logic [15:0] RST_LONG_CMD    = 16'd2000;
    localparam logic [15:0] RST_POWER_ON    = 16'd40000;

    localparam logic [15:0] WAIT_FIRST_US = 16'd5000;
    localparam logic [15:0] WAIT_SHORT_US = 16'd150;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd28;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BYTE,
        ST_INIT
    } state_t;

    typedef enum logic [2:0] {
        HOLD_ENABLE,
        HOLD_SETTLE,
        HOLD_LONG,
        HOLD_POWER,
        HOLD_WAIT_FIRST,
        HOLD_WAIT_SHORT
    } hold_sel_t;

    typedef enum logic [1:0] {
        NIB_HI,
        NIB_LO,
        NIB_CONST
    } nib_src_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       en;
        hold_sel_t  hold_sel;
    } init_entry_t;

    // command from controller to datapath
    typedef struct packed {
        logic       load;
        logic       emit;
        nib_src_t   nib_src;
        logic [3:0] nib_const;
        logic       en;
        hold_sel_t  hold_sel;
        logic       rs_zero;
        logic       last;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic is_long;
    } dp_status_t;

    // power-on sequence, one pin state per step
    function automatic init_entry_t init_entry(input logic [STEP_W-1:0] idx);
        init_entry_t e;
        e = '{nibble: 4'h0, en: 1'b0, hold_sel: HOLD_SETTLE};
        unique case (idx)
            5'd0:  e = '{4'h0, 1'b0, HOLD_POWER};
            5'd1:  e = '{4'h3, 1'b1, HOLD_ENABLE};
            5'd2:  e = '{4'h3, 1'b0, HOLD_SETTLE};
            5'd3:  e = '{4'h3, 1'b0, HOLD_WAIT_FIRST};
            5'd4:  e = '{4'h3, 1'b1, HOLD_ENABLE};
            5'd5:  e = '{4'h3, 1'b0, HOLD_SETTLE};
            5'd6:  e = '{4'h3, 1'b0, HOLD_WAIT_SHORT};
            5'd7:  e = '{4'h3, 1'b1, HOLD_ENABLE};
            5'd8:  e = '{4'h3, 1'b0, HOLD_SETTLE};
            5'd9:  e = '{4'h3, 1'b0, HOLD_WAIT_SHORT};
            5'd10: e = '{4'h2, 1'b1, HOLD_ENABLE};
            5'd11: e = '{4'h2, 1'b0, HOLD_SETTLE};
            5'd12: e = '{4'h2, 1'b1, HOLD_ENABLE};
            5'd13: e = '{4'h2, 1'b0, HOLD_SETTLE};
            5'd14: e = '{4'h8, 1'b1, HOLD_ENABLE};
            5'd15: e = '{4'h8, 1'b0, HOLD_SETTLE};
            5'd16: e = '{4'h0, 1'b1, HOLD_ENABLE};
            5'd17: e = '{4'h0, 1'b0, HOLD_SETTLE};
            5'd18: e = '{4'hC, 1'b1, HOLD_ENABLE};
            5'd19: e = '{4'hC, 1'b0, HOLD_SETTLE};
            5'd20: e = '{4'h0, 1'b1, HOLD_ENABLE};
            5'd21: e = '{4'h0, 1'b0, HOLD_SETTLE};
            5'd22: e = '{4'h6, 1'b1, HOLD_ENABLE};
            5'd23: e = '{4'h6, 1'b0, HOLD_SETTLE};
            5'd24: e = '{4'h0, 1'b1, HOLD_ENABLE};
            5'd25: e = '{4'h0, 1'b0, HOLD_SETTLE};
            5'd26: e = '{4'h1, 1'b1, HOLD_ENABLE};
            5'd27: e = '{4'h1, 1'b0, HOLD_SETTLE};
            5'd28: e = '{4'h1, 1'b0, HOLD_LONG};
            default: e = '{4'h0, 1'b0, HOLD_SETTLE};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

### sv/clns_ctrl.sv
// controller state machine: steps through the pin states of one item
`default_nettype none
module clns_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_func,
    output logic                     in_ready,
    input  wire clns_pkg::dp_status_t status,
    output clns_pkg::dp_cmd_t        cmd
);
    import clns_pkg::*;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    init_entry_t         ie;
    logic                accept;

    assign accept = in_valid && in_ready;
    assign ie     = init_entry(step_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = in_func ? ST_INIT : ST_BYTE;
                    step_next  = '0;
                end
            end
            ST_BYTE, ST_INIT: begin
                if (cmd.emit) begin
                    step_next = step_reg + 1'b1;
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.nib_src   = NIB_HI;
        cmd.hold_sel  = HOLD_SETTLE;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_BYTE: begin
                cmd.emit = status.out_free;
                unique case (step_reg[2:0])
                    3'd0: begin
                        cmd.nib_src  = NIB_HI;
                        cmd.en       = 1'b1;
                        cmd.hold_sel = HOLD_ENABLE;
                    end
                    3'd1: begin
                        cmd.nib_src  = NIB_HI;
                        cmd.hold_sel = HOLD_SETTLE;
                    end
                    3'd2: begin
                        cmd.nib_src  = NIB_LO;
                        cmd.en       = 1'b1;
                        cmd.hold_sel = HOLD_ENABLE;
                    end
                    3'd3: begin
                        cmd.nib_src  = NIB_LO;
                        cmd.hold_sel = HOLD_SETTLE;
                        cmd.last     = !status.is_long;
                    end
                    3'd4: begin
                        // clear or home idle
                        cmd.nib_src  = NIB_LO;
                        cmd.hold_sel = HOLD_LONG;
                        cmd.rs_zero  = 1'b1;
                        cmd.last     = 1'b1;
                    end
                    default: begin
                        cmd.emit = 1'b0;
                    end
                endcase
            end
            ST_INIT: begin
                cmd.emit      = status.out_free;
                cmd.nib_src   = NIB_CONST;
                cmd.nib_const = ie.nibble;
                cmd.en        = ie.en;
                cmd.hold_sel  = ie.hold_sel;
                cmd.rs_zero   = 1'b1;
                cmd.last      = (step_reg == INIT_LAST_STEP);
            end
            default: begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/clns_datapath.sv
// datapath: timing registers, input latch and output word register
`default_nettype none
module clns_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [clns_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    input  wire logic [7:0]                     in_value,
    input  wire logic                           in_rs,
    input  wire clns_pkg::dp_cmd_t              cmd,
    output clns_pkg::dp_status_t                status,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                out_rs,
    output logic [3:0]                          out_nibble,
    output logic                                out_en,
    output logic [15:0]                         out_hold,
    output logic                                out_last
);
    import clns_pkg::*;

    logic [7:0]  enable_high_reg;
    logic [15:0] settle_reg;
    logic [15:0] long_cmd_reg;
    logic [15:0] power_on_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    logic [7:0]  value_reg;
    logic        rs_reg;

    logic        valid_reg;
    logic        rs_out_reg;
    logic [3:0]  nib_out_reg;
    logic        en_out_reg;
    logic [15:0] hold_out_reg;
    logic        last_out_reg;

    logic [3:0]  nib_next;
    logic [15:0] hold_next;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            enable_high_reg <= RST_ENABLE_HIGH;
            settle_reg      <= RST_SETTLE;
            long_cmd_reg    <= RST_LONG_CMD;
            power_on_reg    <= RST_POWER_ON;
        end
        else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENABLE_HIGH: enable_high_reg <= pwdata[7:0];
                REG_SETTLE:      settle_reg      <= pwdata[15:0];
                REG_LONG_CMD:    long_cmd_reg    <= pwdata[15:0];
                REG_POWER_ON:    power_on_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ENABLE_HIGH: prdata = {24'd0, enable_high_reg};
            REG_SETTLE:      prdata = {16'd0, settle_reg};
            REG_LONG_CMD:    prdata = {16'd0, long_cmd_reg};
            REG_POWER_ON:    prdata = {16'd0, power_on_reg};
            default:         prdata = '0;
        endcase
    end

    // captured byte and select
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            value_reg <= in_value;
            rs_reg    <= in_rs;
        end
    end

    assign status = '{out_free: !valid_reg || out_ready,
                      is_long:  !rs_reg && (value_reg == CMD_CLEAR || value_reg == CMD_HOME)};

    always_comb begin
        unique case (cmd.nib_src)
            NIB_HI:    nib_next = value_reg[7:4];
            NIB_LO:    nib_next = value_reg[3:0];
            NIB_CONST: nib_next = cmd.nib_const;
            default:   nib_next = value_reg[3:0];
        endcase
    end

    always_comb begin
        unique case (cmd.hold_sel)
            HOLD_ENABLE:     hold_next = {8'd0, enable_high_reg};
            HOLD_SETTLE:     hold_next = settle_reg;
            HOLD_LONG:       hold_next = long_cmd_reg;
            HOLD_POWER:      hold_next = power_on_reg;
            HOLD_WAIT_FIRST: hold_next = WAIT_FIRST_US;
            HOLD_WAIT_SHORT: hold_next = WAIT_SHORT_US;
            default:         hold_next = settle_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.emit) begin
            rs_out_reg   <= rs_reg && !cmd.rs_zero;
            nib_out_reg  <= nib_next;
            en_out_reg   <= cmd.en;
            hold_out_reg <= hold_next;
            last_out_reg <= cmd.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rs     = rs_out_reg;
    assign out_nibble = nib_out_reg;
    assign out_en     = en_out_reg;
    assign out_hold   = hold_out_reg;
    assign out_last   = last_out_reg;

endmodule
`default_nettype wire

### sv/char_lcd_nibble_sequencer.sv
// top level of the character lcd 4-bit nibble sequencer
//
// Turns each input word into a list of output words, one per pin state of a
// character LCD on a 4-bit bus, each with the time in microseconds it is held.
// A byte write (s_axis_tuser[0] = 0) sends the high and then the low nibble,
// each as an enable-high state and an enable-low settle state; a clear or home
// command with select 0 adds a long idle state, so a byte gives 4 or 5 words.
// An init word (s_axis_tuser[0] = 1) gives the whole 29-state power-on sequence.
// The controller walks one step per cycle and loads one output word per cycle
// while the output register is free; it accepts no new input word until the
// last word of the current one is loaded. Timing registers sit on the APB port
// at byte addresses 0 (enable high), 4 (settle), 8 (long command) and 12 (power
// on) and should be written only while no word is in flight.
`default_nettype none
module char_lcd_nibble_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [0] func, [1] reg_select
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [3:0] bus_nibble, [4] enable_level,
                                             // [20:5] hold_us, [23:21] zero
    output logic             m_axis_tuser,   // [0] rs_level
    output logic             m_axis_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import clns_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [3:0]  nib;
    logic        en;
    logic [15:0] hold;

    // no wait states on the register port
    assign pready = 1'b1;

    // sequencer, one step per emitted word
    clns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // registers, byte latch and output word
    clns_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .in_value   (s_axis_tdata),
        .in_rs      (s_axis_tuser[1]),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_rs     (m_axis_tuser),
        .out_nibble (nib),
        .out_en     (en),
        .out_hold   (hold),
        .out_last   (m_axis_tlast)
    );

    // pack the pin state word
    assign m_axis_tdata = {3'b000, hold, en, nib};

endmodule
`default_nettype wire

### sv/clns_checker.sv
// port-level checks for the lcd nibble sequencer, bound to the top level
`default_nettype none
module clns_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        pready
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous item in flight");

    // an enable pulse never ends a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tlast)
        else $error("sequence ended with enable high");

    // padding bits stay zero and pready is high while a word is valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000 && pready)
        else $error("nonzero padding or register port stall");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (.*);
`default_nettype wire
